/* rtl/core/dlpc_pkg.sv */
package dlpc_pkg;

   localparam int REF_W   = 24;
   localparam int ERR_W   = 25;
   localparam int DIFF_W  = 26;
   localparam int GAIN_W  = 32;
   localparam int DRIVE_W = 17;
   localparam int IDX_W   = 3;
   localparam int OUT_FRAC_BITS = 12;

   typedef enum logic [1:0] {
      OP_POS   = 2'd0,
      OP_FORCE = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   localparam logic [IDX_W-1:0] REG_POS_P   = 3'd0;
   localparam logic [IDX_W-1:0] REG_POS_I   = 3'd1;
   localparam logic [IDX_W-1:0] REG_POS_D   = 3'd2;
   localparam logic [IDX_W-1:0] REG_FORCE_P = 3'd3;
   localparam logic [IDX_W-1:0] REG_FORCE_I = 3'd4;
   localparam logic [IDX_W-1:0] REG_FORCE_D = 3'd5;
   localparam logic [IDX_W-1:0] REG_MOTOR_K = 3'd6;

   localparam logic signed [GAIN_W-1:0] RST_POS_P   = 32'sd31038;
   localparam logic signed [GAIN_W-1:0] RST_POS_I   = 32'sd252;
   localparam logic signed [GAIN_W-1:0] RST_POS_D   = 32'sd88080;
   localparam logic signed [GAIN_W-1:0] RST_FORCE_P = 32'sd148101;
   localparam logic signed [GAIN_W-1:0] RST_FORCE_I = 32'sd59240;
   localparam logic signed [GAIN_W-1:0] RST_FORCE_D = 32'sd0;
   localparam logic signed [GAIN_W-1:0] RST_MOTOR_K = 32'sd380105;

   // 1/4096 A units: 10 A, -1 A, 6 A, -2 A
   localparam logic signed [DRIVE_W-1:0] POS_HI_LIM   = 17'sd40960;
   localparam logic signed [DRIVE_W-1:0] POS_LO_LIM   = -17'sd4096;
   localparam logic signed [DRIVE_W-1:0] FORCE_HI_LIM = 17'sd24576;
   localparam logic signed [DRIVE_W-1:0] FORCE_LO_LIM = -17'sd8192;

endpackage

/* rtl/core/dlpc_err_state.sv */
module dlpc_err_state
   import dlpc_pkg::*;
#(
   parameter int SUM_BITS = 48
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  op_type                     op,
   input  logic signed [REF_W-1:0]    reference,
   input  logic signed [REF_W-1:0]    measured,
   output logic signed [ERR_W-1:0]    err,
   output logic signed [DIFF_W-1:0]   diff,
   output logic signed [SUM_BITS-1:0] sum
);

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   logic signed [ERR_W-1:0]    pos_prev_ff, pos_prev_in;
   logic signed [ERR_W-1:0]    force_prev_ff, force_prev_in;
   logic signed [SUM_BITS-1:0] pos_sum_ff, pos_sum_in;
   logic signed [SUM_BITS-1:0] force_sum_ff, force_sum_in;

   logic signed [SUM_BITS:0]   pos_wide;
   logic signed [SUM_BITS:0]   force_wide;
   logic signed [SUM_BITS-1:0] pos_sat;
   logic signed [SUM_BITS-1:0] force_sat;

   assign err = ERR_W'(reference) - ERR_W'(measured);

   assign pos_wide   = (SUM_BITS+1)'(pos_sum_ff) + (SUM_BITS+1)'(err);
   assign force_wide = (SUM_BITS+1)'(force_sum_ff) + (SUM_BITS+1)'(err);

   always_comb begin
      if (pos_wide[SUM_BITS] != pos_wide[SUM_BITS-1]) begin
         pos_sat = pos_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         pos_sat = pos_wide[SUM_BITS-1:0];
      end
      if (force_wide[SUM_BITS] != force_wide[SUM_BITS-1]) begin
         force_sat = force_wide[SUM_BITS] ? SUM_MIN : SUM_MAX;
      end else begin
         force_sat = force_wide[SUM_BITS-1:0];
      end
   end

   always_comb begin
      pos_prev_in   = pos_prev_ff;
      pos_sum_in    = pos_sum_ff;
      force_prev_in = force_prev_ff;
      force_sum_in  = force_sum_ff;
      diff          = '0;
      sum           = '0;
      unique case (op)
         OP_POS: begin
            diff        = DIFF_W'(err) - DIFF_W'(pos_prev_ff);
            sum         = pos_sat;
            pos_prev_in = err;
            pos_sum_in  = pos_sat;
         end
         OP_FORCE: begin
            diff          = DIFF_W'(err) - DIFF_W'(force_prev_ff);
            sum           = force_sat;
            force_prev_in = err;
            force_sum_in  = force_sat;
         end
         OP_CLEAR: begin
            pos_prev_in   = '0;
            pos_sum_in    = '0;
            force_prev_in = '0;
            force_sum_in  = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_prev_ff   <= '0;
         pos_sum_ff    <= '0;
         force_prev_ff <= '0;
         force_sum_ff  <= '0;
      end else if (advance) begin
         pos_prev_ff   <= pos_prev_in;
         pos_sum_ff    <= pos_sum_in;
         force_prev_ff <= force_prev_in;
         force_sum_ff  <= force_sum_in;
      end
   end

endmodule

/* rtl/core/dual_loop_pid_current_controller.sv */
// Throughput: one request per cycle unless response backpressure stalls the pipeline;
// the loop error state updates in stage 2 and the gain products, partial sums and
// clamp run in separate pipeline stages.
// Backpressure on the response side stalls only the stages that are occupied.
// Reset (synchronous): empties the pipeline, zeroes the loop error state and
// restores every gain register to its reset value.
module dual_loop_pid_current_controller
   import dlpc_pkg::*;
#(
   parameter int SUM_BITS       = 48,
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [47:0]        req_tdata,   // reference[23:0], measured[47:24]
   input  logic [1:0]         req_tuser,   // operation[1:0]
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [23:0]        rsp_tdata,   // drive_current[16:0], zero[23:17]
   output logic [0:0]         rsp_tuser,   // limited[0]
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [GAIN_W-1:0]  csr_data
);

   localparam int LO_BITS = SUM_BITS / 2;
   localparam int HI_BITS = SUM_BITS - LO_BITS;
   localparam int PE_W    = GAIN_W + ERR_W;
   localparam int PD_W    = GAIN_W + DIFF_W;
   localparam int PM_W    = GAIN_W + REF_W;
   localparam int PLO_W   = GAIN_W + LO_BITS + 1;
   localparam int PHI_W   = GAIN_W + HI_BITS;
   localparam int PA_W    = PD_W + 2;
   localparam int PB_W    = GAIN_W + SUM_BITS + 1;
   localparam int ACC_W   = GAIN_W + SUM_BITS + 3;
   localparam int SHIFT   = GAIN_FRAC_BITS - OUT_FRAC_BITS;

   // gain registers
   logic signed [GAIN_W-1:0] pos_p_ff, pos_i_ff, pos_d_ff;
   logic signed [GAIN_W-1:0] force_p_ff, force_i_ff, force_d_ff, motor_k_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_p_ff   <= RST_POS_P;
         pos_i_ff   <= RST_POS_I;
         pos_d_ff   <= RST_POS_D;
         force_p_ff <= RST_FORCE_P;
         force_i_ff <= RST_FORCE_I;
         force_d_ff <= RST_FORCE_D;
         motor_k_ff <= RST_MOTOR_K;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_POS_P:   pos_p_ff   <= csr_data;
            REG_POS_I:   pos_i_ff   <= csr_data;
            REG_POS_D:   pos_d_ff   <= csr_data;
            REG_FORCE_P: force_p_ff <= csr_data;
            REG_FORCE_I: force_i_ff <= csr_data;
            REG_FORCE_D: force_d_ff <= csr_data;
            REG_MOTOR_K: motor_k_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // pipeline flow control
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy_out;

   assign rdy_out    = !rsp_valid_ff || rsp_tready;
   assign rdy5       = !v5_ff || rdy_out;
   assign rdy4       = !v4_ff || rdy5;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1)    v1_ff        <= req_tvalid;
         if (rdy2)    v2_ff        <= v1_ff;
         if (rdy3)    v3_ff        <= v2_ff;
         if (rdy4)    v4_ff        <= v3_ff;
         if (rdy5)    v5_ff        <= v4_ff;
         if (rdy_out) rsp_valid_ff <= v5_ff;
      end
   end

   // stage 1: input register
   op_type                  s1_op_ff;
   logic signed [REF_W-1:0] s1_ref_ff, s1_meas_ff;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_op_ff   <= op_type'(req_tuser);
         s1_ref_ff  <= req_tdata[REF_W-1:0];
         s1_meas_ff <= req_tdata[2*REF_W-1:REF_W];
      end
   end

   // stage 2: loop errors and error sums
   logic signed [ERR_W-1:0]    err_in;
   logic signed [DIFF_W-1:0]   diff_in;
   logic signed [SUM_BITS-1:0] sum_in;

   dlpc_err_state #(
      .SUM_BITS (SUM_BITS)
   ) u_err_state (
      .clock     (clock),
      .reset     (reset),
      .advance   (rdy2 && v1_ff),
      .op        (s1_op_ff),
      .reference (s1_ref_ff),
      .measured  (s1_meas_ff),
      .err       (err_in),
      .diff      (diff_in),
      .sum       (sum_in)
   );

   op_type                     s2_op_ff;
   logic signed [REF_W-1:0]    s2_ref_ff;
   logic signed [ERR_W-1:0]    s2_err_ff;
   logic signed [DIFF_W-1:0]   s2_diff_ff;
   logic signed [SUM_BITS-1:0] s2_sum_ff;

   always_ff @(posedge clock) begin
      if (rdy2) begin
         s2_op_ff   <= s1_op_ff;
         s2_ref_ff  <= s1_ref_ff;
         s2_err_ff  <= err_in;
         s2_diff_ff <= diff_in;
         s2_sum_ff  <= sum_in;
      end
   end

   // stage 3: gain products
   logic signed [GAIN_W-1:0]  gain_p, gain_i, gain_d, gain_m;
   logic signed [LO_BITS:0]   sum_lo;
   logic signed [HI_BITS-1:0] sum_hi;

   always_comb begin
      gain_p = '0;
      gain_i = '0;
      gain_d = '0;
      gain_m = '0;
      unique case (s2_op_ff)
         OP_POS: begin
            gain_p = pos_p_ff;
            gain_i = pos_i_ff;
            gain_d = pos_d_ff;
         end
         OP_FORCE: begin
            gain_p = force_p_ff;
            gain_i = force_i_ff;
            gain_d = force_d_ff;
            gain_m = motor_k_ff;
         end
         default: begin
         end
      endcase
   end

   assign sum_lo = {1'b0, s2_sum_ff[LO_BITS-1:0]};
   assign sum_hi = s2_sum_ff[SUM_BITS-1:LO_BITS];

   op_type                  s3_op_ff;
   logic signed [PE_W-1:0]  prod_e_ff, prod_e_in;
   logic signed [PD_W-1:0]  prod_d_ff, prod_d_in;
   logic signed [PM_W-1:0]  prod_m_ff, prod_m_in;
   logic signed [PLO_W-1:0] prod_lo_ff, prod_lo_in;
   logic signed [PHI_W-1:0] prod_hi_ff, prod_hi_in;

   assign prod_e_in  = gain_p * s2_err_ff;
   assign prod_d_in  = gain_d * s2_diff_ff;
   assign prod_m_in  = gain_m * s2_ref_ff;
   assign prod_lo_in = gain_i * sum_lo;
   assign prod_hi_in = gain_i * sum_hi;

   always_ff @(posedge clock) begin
      if (rdy3) begin
         s3_op_ff   <= s2_op_ff;
         prod_e_ff  <= prod_e_in;
         prod_d_ff  <= prod_d_in;
         prod_m_ff  <= prod_m_in;
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
      end
   end

   // stage 4: partial sums
   op_type                 s4_op_ff;
   logic signed [PA_W-1:0] part_a_ff, part_a_in;
   logic signed [PB_W-1:0] part_b_ff, part_b_in;

   assign part_a_in = PA_W'(prod_e_ff) + PA_W'(prod_d_ff) + PA_W'(prod_m_ff);
   assign part_b_in = (PB_W'(prod_hi_ff) <<< LO_BITS) + PB_W'(prod_lo_ff);

   always_ff @(posedge clock) begin
      if (rdy4) begin
         s4_op_ff  <= s3_op_ff;
         part_a_ff <= part_a_in;
         part_b_ff <= part_b_in;
      end
   end

   // stage 5: full drive sum
   op_type                  s5_op_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   assign acc_in = ACC_W'(part_a_ff) + ACC_W'(part_b_ff);

   always_ff @(posedge clock) begin
      if (rdy5) begin
         s5_op_ff <= s4_op_ff;
         acc_ff   <= acc_in;
      end
   end

   // output stage: scale to 1/4096 A and clamp; operations other than loop ones drive zero
   logic signed [ACC_W-1:0]   scaled;
   logic signed [DRIVE_W-1:0] hi_lim, lo_lim;
   logic signed [DRIVE_W-1:0] drive_in, drive_ff;
   logic                      limited_in, limited_ff;
   logic                      loop_op;

   assign scaled = acc_ff >>> SHIFT;

   always_comb begin
      hi_lim  = POS_HI_LIM;
      lo_lim  = POS_LO_LIM;
      loop_op = 1'b0;
      unique case (s5_op_ff)
         OP_POS: begin
            loop_op = 1'b1;
         end
         OP_FORCE: begin
            hi_lim  = FORCE_HI_LIM;
            lo_lim  = FORCE_LO_LIM;
            loop_op = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      drive_in   = '0;
      limited_in = 1'b0;
      if (loop_op) begin
         priority if (scaled > ACC_W'(hi_lim)) begin
            drive_in   = hi_lim;
            limited_in = 1'b1;
         end else if (scaled < ACC_W'(lo_lim)) begin
            drive_in   = lo_lim;
            limited_in = 1'b1;
         end else begin
            drive_in = scaled[DRIVE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         drive_ff   <= drive_in;
         limited_ff <= limited_in;
      end
   end

   assign rsp_tdata = {{(24-DRIVE_W){1'b0}}, drive_ff};
   assign rsp_tuser = limited_ff;

endmodule

/* tb/dlpc_drive_checker.sv */
`timescale 1ns / 1ps
module dlpc_drive_checker
   import dlpc_pkg::*;
#(
   parameter int SUM_BITS       = 48,
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [47:0]       req_tdata,   // reference[23:0], measured[47:24]
   input  logic [1:0]        req_tuser,   // operation[1:0]
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [23:0]       rsp_tdata,   // drive_current[16:0], zero[23:17]
   input  logic [0:0]        rsp_tuser,   // limited[0]
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [GAIN_W-1:0] csr_data,
   output int                mismatches,
   output int                outstanding
);

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      limited;
   } drive_type;

   localparam logic signed [63:0] SUM_MAX = (64'sd1 <<< (SUM_BITS - 1)) - 64'sd1;
   localparam logic signed [63:0] SUM_MIN = -SUM_MAX - 64'sd1;

   logic signed [GAIN_W-1:0]   loop_gain [0:6];
   logic signed [ERR_W-1:0]    pos_last_err;
   logic signed [ERR_W-1:0]    force_last_err;
   logic signed [SUM_BITS-1:0] pos_err_acc;
   logic signed [SUM_BITS-1:0] force_err_acc;
   drive_type                  expected_drives [$];

   function automatic logic signed [63:0] sum_add(input logic signed [63:0] sum,
                                                  input logic signed [63:0] err);
      logic signed [63:0] total;
      total = sum + err;
      if (total > SUM_MAX) return SUM_MAX;
      if (total < SUM_MIN) return SUM_MIN;
      return total;
   endfunction

   function automatic logic signed [127:0] mul_gain(input logic signed [GAIN_W-1:0] g,
                                                    input logic signed [63:0] x);
      logic signed [127:0] gw;
      logic signed [127:0] xw;
      gw = g;
      xw = x;
      return gw * xw;
   endfunction

   function automatic drive_type clamp_drive(input logic signed [127:0] acc,
                                             input logic signed [DRIVE_W-1:0] lo,
                                             input logic signed [DRIVE_W-1:0] hi);
      logic signed [127:0] amps;
      logic signed [127:0] lo_w;
      logic signed [127:0] hi_w;
      drive_type           r;
      lo_w = lo;
      hi_w = hi;
      // floor to 1/4096 A
      amps = acc >>> (GAIN_FRAC_BITS - OUT_FRAC_BITS);
      r.limited = 1'b0;
      if (amps > hi_w) begin
         r.drive   = hi;
         r.limited = 1'b1;
      end else if (amps < lo_w) begin
         r.drive   = lo;
         r.limited = 1'b1;
      end else begin
         r.drive = amps[DRIVE_W-1:0];
      end
      return r;
   endfunction

   task automatic advance_loops(input logic [1:0] op,
                                input logic signed [REF_W-1:0] target,
                                input logic signed [REF_W-1:0] sensed,
                                output drive_type drive);
      logic signed [63:0]  t64;
      logic signed [63:0]  s64;
      logic signed [63:0]  err;
      logic signed [63:0]  prev;
      logic signed [63:0]  sum;
      logic signed [127:0] acc;
      t64   = target;
      s64   = sensed;
      err   = t64 - s64;
      drive = '0;
      case (op)
         OP_POS: begin
            prev = pos_last_err;
            sum  = pos_err_acc;
            sum  = sum_add(sum, err);
            pos_err_acc  = sum[SUM_BITS-1:0];
            pos_last_err = err[ERR_W-1:0];
            acc = mul_gain(loop_gain[REG_POS_P], err)
                + mul_gain(loop_gain[REG_POS_I], sum)
                + mul_gain(loop_gain[REG_POS_D], err - prev);
            drive = clamp_drive(acc, POS_LO_LIM, POS_HI_LIM);
         end
         OP_FORCE: begin
            prev = force_last_err;
            sum  = force_err_acc;
            sum  = sum_add(sum, err);
            force_err_acc  = sum[SUM_BITS-1:0];
            force_last_err = err[ERR_W-1:0];
            acc = mul_gain(loop_gain[REG_MOTOR_K], t64)
                + mul_gain(loop_gain[REG_FORCE_P], err)
                + mul_gain(loop_gain[REG_FORCE_I], sum)
                + mul_gain(loop_gain[REG_FORCE_D], err - prev);
            drive = clamp_drive(acc, FORCE_LO_LIM, FORCE_HI_LIM);
         end
         OP_CLEAR: begin
            pos_last_err   = '0;
            pos_err_acc    = '0;
            force_last_err = '0;
            force_err_acc  = '0;
         end
         default: ;
      endcase
   endtask

   task automatic count_mismatch(input drive_type want, input drive_type got,
                                 input bit orphan);
      mismatches++;
      if (mismatches <= 10) begin
         if (orphan)
            $display("%0t: response with no request pending: drive=%0d limited=%0d",
                     $time, got.drive, got.limited);
         else
            $display("%0t: drive mismatch: expected drive=%0d limited=%0d, %s%0d %s%0d",
                     $time, want.drive, want.limited, "got drive=", got.drive,
                     "limited=", got.limited);
      end
   endtask

   always @(posedge clock) begin : watch
      drive_type want;
      drive_type got;
      if (reset) begin
         loop_gain[REG_POS_P]   = RST_POS_P;
         loop_gain[REG_POS_I]   = RST_POS_I;
         loop_gain[REG_POS_D]   = RST_POS_D;
         loop_gain[REG_FORCE_P] = RST_FORCE_P;
         loop_gain[REG_FORCE_I] = RST_FORCE_I;
         loop_gain[REG_FORCE_D] = RST_FORCE_D;
         loop_gain[REG_MOTOR_K] = RST_MOTOR_K;
         pos_last_err   = '0;
         pos_err_acc    = '0;
         force_last_err = '0;
         force_err_acc  = '0;
         mismatches     = 0;
         expected_drives.delete();
      end else begin
         if (csr_valid && csr_ready && csr_index <= REG_MOTOR_K)
            loop_gain[csr_index] = csr_data;
         if (req_tvalid && req_tready) begin
            advance_loops(req_tuser, req_tdata[REF_W-1:0], req_tdata[2*REF_W-1:REF_W], want);
            expected_drives.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got.drive   = rsp_tdata[DRIVE_W-1:0];
            got.limited = rsp_tuser[0];
            if (expected_drives.size() == 0) begin
               count_mismatch(got, got, 1'b1);
            end else begin
               want = expected_drives.pop_front();
               if (got.drive !== want.drive || got.limited !== want.limited)
                  count_mismatch(want, got, 1'b0);
            end
         end
      end
      outstanding <= expected_drives.size();
   end

endmodule

/* tb/dual_loop_pid_current_controller_tb.sv */
`timescale 1ns / 1ps
module dual_loop_pid_current_controller_tb
   import dlpc_pkg::*;
();

   localparam int RUN_LIMIT   = 200000;
   localparam int PIPE_DRAIN  = 8;
   localparam int HOLD_CYCLES = 200;
   localparam int PHASE_ITEMS = 225;
   localparam int NUM_PHASES  = 6;
   localparam int IDLE_PCT    = 21;

   localparam logic [1:0]              OP_SPARE   = 2'd3;
   localparam logic [IDX_W-1:0]        REG_UNUSED = 3'd7;
   localparam logic signed [REF_W-1:0] REF_MAX    = 24'sh7FFFFF;
   localparam logic signed [REF_W-1:0] REF_MIN    = 24'sh800000;
   localparam logic [GAIN_W-1:0]       GAIN_MAX   = 32'h7FFFFFFF;
   localparam logic [GAIN_W-1:0]       GAIN_MIN   = 32'h80000000;
   localparam logic [GAIN_W-1:0]       GAIN_UNIT  = 32'd4096;
   localparam logic [GAIN_W-1:0]       GAIN_LSB   = 32'd1;
   localparam logic [GAIN_W-1:0]       GAIN_ZERO  = 32'd0;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [47:0]       req_tdata  = '0;
   logic [1:0]        req_tuser  = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [23:0]       rsp_tdata;
   logic [0:0]        rsp_tuser;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [IDX_W-1:0]  csr_index  = '0;
   logic [GAIN_W-1:0] csr_data   = '0;
   int                mismatches;
   int                outstanding;
   int                hold_asks  = 0;
   bit                steady     = 1'b0;
   int                cycles     = 0;

   dual_loop_pid_current_controller i_dut (.*);

   dlpc_drive_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin : receiver
      int seen_holds;
      int held;
      seen_holds = 0;
      forever begin
         @(posedge clock);
         if (hold_asks != seen_holds) begin
            seen_holds = hold_asks;
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(posedge clock);
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic put_request(input logic [1:0] op,
                              input logic signed [REF_W-1:0] target,
                              input logic signed [REF_W-1:0] sensed);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {sensed, target};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_gains(input logic [GAIN_W-1:0] pp, input logic [GAIN_W-1:0] pi,
                            input logic [GAIN_W-1:0] pd, input logic [GAIN_W-1:0] fp,
                            input logic [GAIN_W-1:0] fi, input logic [GAIN_W-1:0] fd,
                            input logic [GAIN_W-1:0] mk);
      write_reg(REG_POS_P, pp);
      write_reg(REG_POS_I, pi);
      write_reg(REG_POS_D, pd);
      write_reg(REG_FORCE_P, fp);
      write_reg(REG_FORCE_I, fi);
      write_reg(REG_FORCE_D, fd);
      write_reg(REG_MOTOR_K, mk);
   endtask

   task automatic drain_results;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] random_gain(input int span);
      int g;
      g = $urandom_range(2 * span) - span;
      return g;
   endfunction

   task automatic random_request;
      int                      pick;
      int                      span;
      int                      t;
      int                      s;
      logic [1:0]              op;
      logic signed [REF_W-1:0] target;
      logic signed [REF_W-1:0] sensed;
      pick = $urandom_range(99);
      op = pick < 46 ? OP_POS : pick < 92 ? OP_FORCE : pick < 97 ? OP_CLEAR : OP_SPARE;
      case ($urandom_range(3))
         0:       span = 300;
         1:       span = 6000;
         2:       span = 200000;
         default: span = 0;
      endcase
      if (span == 0) begin
         target = REF_W'($urandom);
         sensed = REF_W'($urandom);
      end else begin
         // track near the reference: small error, random set point
         t = $urandom_range(2 * span) - span;
         s = t + $urandom_range(span / 2) - span / 4;
         target = t[REF_W-1:0];
         sensed = s[REF_W-1:0];
      end
      put_request(op, target, sensed);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // full-scale errors and feedforward, clear, spare opcode
      put_request(OP_POS, REF_MAX, REF_MIN);
      put_request(OP_POS, REF_MIN, REF_MAX);
      put_request(OP_FORCE, REF_MAX, REF_MAX);
      put_request(OP_FORCE, REF_MIN, REF_MIN);
      put_request(OP_FORCE, 24'sd0, 24'sd0);
      put_request(OP_SPARE, 24'sd123, -24'sd5);
      put_request(OP_CLEAR, REF_MAX, REF_MIN);
      put_request(OP_POS, 24'sd0, 24'sd0);

      // unit gain: drive equals error, hit each limit exactly and one past it
      drain_results();
      set_gains(GAIN_UNIT, GAIN_ZERO, GAIN_ZERO, GAIN_UNIT, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
      put_request(OP_POS, 24'sd40960, 24'sd0);
      put_request(OP_POS, 24'sd40961, 24'sd0);
      put_request(OP_POS, 24'sd0, 24'sd4096);
      put_request(OP_POS, 24'sd0, 24'sd4097);
      put_request(OP_FORCE, 24'sd24576, 24'sd0);
      put_request(OP_FORCE, 24'sd24577, 24'sd0);
      put_request(OP_FORCE, 24'sd0, 24'sd8192);
      put_request(OP_FORCE, 24'sd0, 24'sd8193);

      // tiny gain: fractional drive rounds toward minus infinity
      drain_results();
      write_reg(REG_POS_P, GAIN_LSB);
      write_reg(REG_FORCE_P, GAIN_LSB);
      put_request(OP_POS, 24'sd0, 24'sd1);
      put_request(OP_POS, 24'sd1, 24'sd0);
      put_request(OP_FORCE, 24'sd0, 24'sd1);

      // sum saturation needs about 2^23 full-scale steps, beyond this run's length
      for (phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         case (phase)
            0: set_gains(RST_POS_P, RST_POS_I, RST_POS_D, RST_FORCE_P, RST_FORCE_I,
                         RST_FORCE_D, RST_MOTOR_K);
            1: begin
               set_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX, GAIN_MAX);
               write_reg(REG_UNUSED, $urandom);
            end
            2: set_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN, GAIN_MIN);
            3: begin
               set_gains(random_gain(1 << 19), random_gain(1 << 12), random_gain(1 << 19),
                         random_gain(1 << 19), random_gain(1 << 12), random_gain(1 << 19),
                         random_gain(1 << 19));
               steady <= 1'b1;
            end
            4: begin
               set_gains($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
               steady <= 1'b0;
            end
            default: set_gains(random_gain(1 << 17), random_gain(1 << 10),
                               random_gain(1 << 17), random_gain(1 << 17),
                               random_gain(1 << 10), random_gain(1 << 17),
                               random_gain(1 << 17));
         endcase
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (phase == NUM_PHASES - 1 && n == 60)
               hold_asks <= hold_asks + 1;
            if (phase == 4 && n == 120)
               drain_results();
            random_request();
         end
      end

      drain_results();
      if (mismatches == 0 && outstanding == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/dlpc_pkg.sv
rtl/core/dlpc_err_state.sv
rtl/core/dual_loop_pid_current_controller.sv
tb/dlpc_drive_checker.sv
tb/dual_loop_pid_current_controller_tb.sv
